/* design/gavc_pkg.sv */
// gavc_pkg: shared constants for the group address value cache
// request kinds, result status codes, telegram filter constants and ring size
// no dependencies
package gavc_pkg;

    // request kinds
    localparam logic [2:0] KIND_TELEGRAM = 3'd0;
    localparam logic [2:0] KIND_LOOKUP   = 3'd1;
    localparam logic [2:0] KIND_REMOVE   = 3'd2;
    localparam logic [2:0] KIND_CLEAR    = 3'd3;
    localparam logic [2:0] KIND_LOG      = 3'd4;

    // result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_HIT       = 3'd2;
    localparam logic [2:0] ST_MISS      = 3'd3;
    localparam logic [2:0] ST_DISABLED  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_LOG_ENTRY = 3'd6;
    localparam logic [2:0] ST_LOG_EMPTY = 3'd7;

    // telegram filter: apci bits of the first two bytes
    localparam logic [7:0] B0_MASK   = 8'h03;
    localparam logic [7:0] B1_MASK   = 8'hC0;
    localparam logic [7:0] B1_RESP   = 8'h40;
    localparam logic [7:0] B1_WRITE  = 8'h80;
    localparam logic [3:0] MIN_LEN   = 4'd2;

    // update ring
    localparam int         LOG_DEPTH = 256;
    localparam int         RING_AW   = 8;

endpackage

/* design/gavc_table_ram.sv */
// gavc_table_ram: single write, single read synchronous ram for table entries
// read data registered; contents undefined until written
// no dependencies
module gavc_table_ram #(
    parameter int WIDTH = 132,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/gavc_ring.sv */
// gavc_ring: update ring of recently written group addresses
// slots never written read as zero through per-slot valid bits
// depends on gavc_pkg
module gavc_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [gavc_pkg::RING_AW-1:0] wr_addr,
    input  logic [15:0]                 wr_data,
    input  logic [gavc_pkg::RING_AW-1:0] rd_addr,
    output logic [15:0]                 rd_data
);

    logic [15:0] mem [gavc_pkg::LOG_DEPTH];
    logic [gavc_pkg::LOG_DEPTH-1:0] valid_reg;
    logic [15:0] rd_data_reg;

    // valid bits cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 16'd0;
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/group_address_value_cache.sv */
// group_address_value_cache: sorted group value table with update log ring
// a lookup runs a binary search over the table; a telegram that inserts a new entry,
// or a remove, also shifts the entries behind the slot one at a time; a clear needs no
// table access; a log query scans ring slots from the start position; one request at a time
// result strobed on done for one cycle, receiver cannot stall
// reset: table empty, ring slots read as zero, log position zero, cache disabled
module group_address_value_cache #(
    parameter int TABLE_ENTRIES = 64,
    parameter int VALUE_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] group_addr,
    input  logic [15:0] source_addr,
    input  logic [3:0]  apdu_len,
    input  logic [63:0] apdu_bytes,
    input  logic [31:0] now_seconds,
    input  logic [15:0] max_age,
    input  logic [15:0] log_start,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] entry_source,
    output logic [15:0] entry_group,
    output logic [3:0]  entry_len,
    output logic [63:0] entry_bytes,
    output logic [15:0] log_next,
    output logic [15:0] log_end
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int VAL_W = VALUE_BYTES * 8;
    localparam int ENT_W = 16 + 16 + 4 + VAL_W + 32;
    // entry layout: {group, source, length, value, stamp}
    localparam int STAMP_LO = 0;
    localparam int VAL_LO   = 32;
    localparam int LEN_LO   = VAL_LO + VAL_W;
    localparam int SRC_LO   = LEN_LO + 4;
    localparam int GRP_LO   = SRC_LO + 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHR,
        S_SHW,
        S_WRITE,
        S_LOGR,
        S_LOGW
    } state_t;

    state_t st_reg;
    logic               enable_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        pos_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg, mid_reg, i_reg, slot_reg;
    logic               found_reg;
    logic [15:0]        scan_reg;

    logic [2:0]         kind_reg;
    logic [15:0]        addr_reg, src_reg;
    logic [3:0]         len_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [31:0]        now_reg;
    logic [15:0]        age_reg;

    logic               done_reg;
    logic [2:0]         status_reg;
    logic [15:0]        source_out_reg, group_out_reg, next_out_reg, end_out_reg;
    logic [3:0]         len_out_reg;
    logic [VAL_W-1:0]   bytes_out_reg;

    logic               accept;
    logic [CNT_W-1:0]   mid;
    logic [3:0]         len_c;
    logic [VAL_W-1:0]   masked;
    logic               filtered;
    logic [15:0]        log_low, start_c;
    logic [ENT_W-1:0]   rd_ent, wr_ent, new_ent;
    logic [IDX_W-1:0]   rd_idx, wr_idx;
    logic               t_we;
    logic [15:0]        rd_group;
    logic               expired;
    logic [15:0]        ring_rd;
    logic               ring_we;

    assign accept = start && (st_reg == S_IDLE);
    assign busy   = (st_reg != S_IDLE);
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);

    // length clamp and byte masking of the incoming apdu
    always_comb
    begin
        len_c = (apdu_len > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : apdu_len;
        for (int k = 0; k < VALUE_BYTES; k++)
        begin
            masked[k*8 +: 8] = (4'(k) < len_c) ? apdu_bytes[k*8 +: 8] : 8'd0;
        end
    end

    // group telegram filter
    assign filtered = (apdu_len < gavc_pkg::MIN_LEN)
        || ((apdu_bytes[7:0] & gavc_pkg::B0_MASK) != 8'd0)
        || (((apdu_bytes[15:8] & gavc_pkg::B1_MASK) != gavc_pkg::B1_RESP)
            && ((apdu_bytes[15:8] & gavc_pkg::B1_MASK) != gavc_pkg::B1_WRITE));

    // log start clamp into the ring window
    always_comb
    begin
        log_low = pos_reg - 16'(gavc_pkg::LOG_DEPTH);
        start_c = log_start;
        if (pos_reg < 16'(gavc_pkg::LOG_DEPTH))
        begin
            if (pos_reg < log_start && log_start < log_low)
            begin
                start_c = log_low;
            end
        end
        else if (log_start < log_low || log_start > pos_reg)
        begin
            start_c = log_low;
        end
    end

    assign new_ent = {addr_reg, src_reg, len_reg, value_reg, now_reg};

    // table ram port control
    always_comb
    begin
        rd_idx = '0;
        wr_idx = i_reg[IDX_W-1:0];
        wr_ent = rd_ent;
        t_we   = 1'b0;
        unique case (st_reg)
            S_SRCH:
            begin
                rd_idx = mid[IDX_W-1:0];
            end
            S_SHR:
            begin
                if (kind_reg == gavc_pkg::KIND_TELEGRAM)
                begin
                    rd_idx = IDX_W'(i_reg - 1'b1);
                end
                else
                begin
                    rd_idx = IDX_W'(i_reg + 1'b1);
                end
            end
            S_SHW:
            begin
                t_we = 1'b1;
            end
            S_WRITE:
            begin
                t_we   = 1'b1;
                wr_idx = slot_reg[IDX_W-1:0];
                wr_ent = new_ent;
            end
            default:
            begin
                rd_idx = '0;
            end
        endcase
    end

    gavc_table_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (t_we),
        .wr_addr (wr_idx),
        .wr_data (wr_ent),
        .rd_addr (rd_idx),
        .rd_data (rd_ent)
    );

    assign ring_we = (st_reg == S_WRITE);

    gavc_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_we),
        .wr_addr (pos_reg[gavc_pkg::RING_AW-1:0]),
        .wr_data (addr_reg),
        .rd_addr (scan_reg[gavc_pkg::RING_AW-1:0]),
        .rd_data (ring_rd)
    );

    assign rd_group = rd_ent[GRP_LO +: 16];
    assign expired  = (age_reg != 16'd0)
        && ((33'(rd_ent[STAMP_LO +: 32]) + 33'(age_reg)) < 33'(now_reg));

    // request sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            enable_reg <= 1'b0;
            count_reg  <= '0;
            pos_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
                if (!cfg_data)
                begin
                    count_reg <= '0;
                end
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= kind;
                        addr_reg       <= group_addr;
                        src_reg        <= source_addr;
                        len_reg        <= len_c;
                        value_reg      <= masked;
                        now_reg        <= now_seconds;
                        age_reg        <= max_age;
                        lo_reg         <= '0;
                        hi_reg         <= count_reg;
                        status_reg     <= gavc_pkg::ST_IGNORED;
                        source_out_reg <= '0;
                        group_out_reg  <= '0;
                        len_out_reg    <= '0;
                        bytes_out_reg  <= '0;
                        next_out_reg   <= '0;
                        end_out_reg    <= '0;
                        priority case (kind)
                            gavc_pkg::KIND_TELEGRAM:
                            begin
                                group_out_reg <= group_addr;
                                if (!enable_reg)
                                begin
                                    status_reg <= gavc_pkg::ST_DISABLED;
                                    done_reg   <= 1'b1;
                                end
                                else if (filtered)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    st_reg <= S_SRCH;
                                end
                            end
                            gavc_pkg::KIND_LOOKUP:
                            begin
                                if (!enable_reg)
                                begin
                                    status_reg <= gavc_pkg::ST_DISABLED;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    group_out_reg <= group_addr;
                                    st_reg        <= S_SRCH;
                                end
                            end
                            gavc_pkg::KIND_REMOVE:
                            begin
                                group_out_reg <= group_addr;
                                st_reg        <= S_SRCH;
                            end
                            gavc_pkg::KIND_CLEAR:
                            begin
                                count_reg  <= '0;
                                status_reg <= gavc_pkg::ST_STORED;
                                done_reg   <= 1'b1;
                            end
                            gavc_pkg::KIND_LOG:
                            begin
                                scan_reg <= start_c;
                                st_reg   <= S_LOGR;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                // binary search step: issue read, or on a miss finish or start the insert shift
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg <= mid;
                        st_reg  <= S_CMP;
                    end
                    else
                    begin
                        slot_reg  <= lo_reg;
                        found_reg <= 1'b0;
                        if (kind_reg == gavc_pkg::KIND_TELEGRAM)
                        begin
                            if (count_reg >= CNT_W'(TABLE_ENTRIES))
                            begin
                                status_reg <= gavc_pkg::ST_FULL;
                                done_reg   <= 1'b1;
                                st_reg     <= S_IDLE;
                            end
                            else
                            begin
                                i_reg  <= count_reg;
                                st_reg <= S_SHR;
                            end
                        end
                        else
                        begin
                            status_reg <= gavc_pkg::ST_MISS;
                            done_reg   <= 1'b1;
                            st_reg     <= S_IDLE;
                        end
                    end
                end
                // compare the read entry against the key
                S_CMP:
                begin
                    if (rd_group == addr_reg)
                    begin
                        slot_reg  <= mid_reg;
                        found_reg <= 1'b1;
                        i_reg     <= mid_reg;
                        priority case (kind_reg)
                            gavc_pkg::KIND_LOOKUP:
                            begin
                                if (expired)
                                begin
                                    status_reg <= gavc_pkg::ST_MISS;
                                end
                                else
                                begin
                                    status_reg     <= gavc_pkg::ST_HIT;
                                    source_out_reg <= rd_ent[SRC_LO +: 16];
                                    len_out_reg    <= rd_ent[LEN_LO +: 4];
                                    bytes_out_reg  <= rd_ent[VAL_LO +: VAL_W];
                                end
                                done_reg <= 1'b1;
                                st_reg   <= S_IDLE;
                            end
                            gavc_pkg::KIND_REMOVE:
                            begin
                                st_reg <= S_SHR;
                            end
                            default:
                            begin
                                st_reg <= S_WRITE;
                            end
                        endcase
                    end
                    else
                    begin
                        if (addr_reg > rd_group)
                        begin
                            lo_reg <= mid_reg + 1'b1;
                        end
                        else
                        begin
                            hi_reg <= mid_reg;
                        end
                        st_reg <= S_SRCH;
                    end
                end
                // shift step: read neighbor, or finish the remove or go on to the write
                S_SHR:
                begin
                    if (kind_reg == gavc_pkg::KIND_TELEGRAM)
                    begin
                        st_reg <= (i_reg > slot_reg) ? S_SHW : S_WRITE;
                    end
                    else if (CNT_W'(i_reg + 1'b1) < count_reg)
                    begin
                        st_reg <= S_SHW;
                    end
                    else
                    begin
                        count_reg  <= count_reg - 1'b1;
                        status_reg <= gavc_pkg::ST_HIT;
                        done_reg   <= 1'b1;
                        st_reg     <= S_IDLE;
                    end
                end
                // shift step: write neighbor into current slot
                S_SHW:
                begin
                    if (kind_reg == gavc_pkg::KIND_TELEGRAM)
                    begin
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    st_reg <= S_SHR;
                end
                // store the new entry and log the address
                S_WRITE:
                begin
                    if (!found_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    pos_reg    <= pos_reg + 16'd1;
                    status_reg <= gavc_pkg::ST_STORED;
                    done_reg   <= 1'b1;
                    st_reg     <= S_IDLE;
                end
                // log scan: issue ring read or report empty
                S_LOGR:
                begin
                    if (scan_reg == pos_reg)
                    begin
                        status_reg   <= gavc_pkg::ST_LOG_EMPTY;
                        next_out_reg <= pos_reg;
                        end_out_reg  <= pos_reg;
                        done_reg     <= 1'b1;
                        st_reg       <= S_IDLE;
                    end
                    else
                    begin
                        st_reg <= S_LOGW;
                    end
                end
                // log scan: check slot, skip empty ones
                S_LOGW:
                begin
                    if (ring_rd != 16'd0)
                    begin
                        status_reg    <= gavc_pkg::ST_LOG_ENTRY;
                        group_out_reg <= ring_rd;
                        next_out_reg  <= scan_reg + 16'd1;
                        end_out_reg   <= pos_reg;
                        done_reg      <= 1'b1;
                        st_reg        <= S_IDLE;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 16'd1;
                        st_reg   <= S_LOGR;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign entry_source = source_out_reg;
    assign entry_group  = group_out_reg;
    assign entry_len    = len_out_reg;
    assign entry_bytes  = 64'(bytes_out_reg);
    assign log_next     = next_out_reg;
    assign log_end      = end_out_reg;

endmodule

/* test/tb_top.sv */
// tb_top: self-checking testbench for group_address_value_cache
// predicts each result from its own copy of the sorted table and update ring
// depends on design/gavc_pkg.sv and design/group_address_value_cache.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 64;
    localparam int BYTES_MAX   = 8;
    localparam int IDLE_LIMIT  = 20000;
    localparam int POOL_SIZE   = 96;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] group_addr;
        logic [15:0] source_addr;
        logic [3:0]  apdu_len;
        logic [63:0] apdu_bytes;
        logic [31:0] now_seconds;
        logic [15:0] max_age;
        logic [15:0] log_start;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_source;
        logic [15:0] entry_group;
        logic [3:0]  entry_len;
        logic [63:0] entry_bytes;
        logic [15:0] log_next;
        logic [15:0] log_end;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_data = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = '0;
    logic [15:0] group_addr = '0;
    logic [15:0] source_addr = '0;
    logic [3:0]  apdu_len = '0;
    logic [63:0] apdu_bytes = '0;
    logic [31:0] now_seconds = '0;
    logic [15:0] max_age = '0;
    logic [15:0] log_start = '0;
    logic        done;
    logic [2:0]  status;
    logic [15:0] entry_source;
    logic [15:0] entry_group;
    logic [3:0]  entry_len;
    logic [63:0] entry_bytes;
    logic [15:0] log_next;
    logic [15:0] log_end;

    // cache copy kept by the predictor
    logic [15:0] cache_group [TABLE_SIZE];
    logic [15:0] cache_source [TABLE_SIZE];
    logic [3:0]  cache_len [TABLE_SIZE];
    logic [63:0] cache_value [TABLE_SIZE];
    logic [31:0] cache_stamp [TABLE_SIZE];
    int          cache_count = 0;
    logic [15:0] ring [gavc_pkg::LOG_DEPTH];
    logic [15:0] ring_position = '0;
    logic        enabled = 1'b0;

    answer_t     pending_answers [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic [15:0] addr_pool [POOL_SIZE];
    logic [31:0] clock_seconds = 32'd1000;

    always #2 clk = ~clk;

    group_address_value_cache dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .start(start), .busy(busy), .kind(kind), .group_addr(group_addr),
        .source_addr(source_addr), .apdu_len(apdu_len), .apdu_bytes(apdu_bytes),
        .now_seconds(now_seconds), .max_age(max_age), .log_start(log_start),
        .done(done), .status(status), .entry_source(entry_source),
        .entry_group(entry_group), .entry_len(entry_len), .entry_bytes(entry_bytes),
        .log_next(log_next), .log_end(log_end)
    );

    // binary search over the sorted table
    function automatic bit find_slot(input logic [15:0] addr, output int slot);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = cache_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (cache_group[mid] == addr)
            begin
                slot = mid;
                return 1'b1;
            end
            if (addr > cache_group[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        slot = lo;
        return 1'b0;
    endfunction

    // expected answer of one request, updating the table copy
    function automatic answer_t cache_predict(input request_t req);
        answer_t     ans;
        int          slot;
        bit          found;
        logic [7:0]  b1;
        int          len;
        logic [15:0] pos;
        logic [15:0] low;
        logic [15:0] at;
        ans = '0;
        ans.status = gavc_pkg::ST_IGNORED;
        case (req.kind)
            gavc_pkg::KIND_TELEGRAM:
            begin
                b1 = req.apdu_bytes[15:8];
                ans.entry_group = req.group_addr;
                if (!enabled)
                    ans.status = gavc_pkg::ST_DISABLED;
                else if (req.apdu_len < gavc_pkg::MIN_LEN ||
                         (req.apdu_bytes[7:0] & gavc_pkg::B0_MASK) != 0 ||
                         ((b1 & gavc_pkg::B1_MASK) != gavc_pkg::B1_RESP &&
                          (b1 & gavc_pkg::B1_MASK) != gavc_pkg::B1_WRITE))
                    ans.status = gavc_pkg::ST_IGNORED;
                else
                begin
                    found = find_slot(req.group_addr, slot);
                    if (!found && cache_count >= TABLE_SIZE)
                        ans.status = gavc_pkg::ST_FULL;
                    else
                    begin
                        if (!found)
                        begin
                            for (int i = cache_count; i > slot; i--)
                            begin
                                cache_group[i]  = cache_group[i-1];
                                cache_source[i] = cache_source[i-1];
                                cache_len[i]    = cache_len[i-1];
                                cache_value[i]  = cache_value[i-1];
                                cache_stamp[i]  = cache_stamp[i-1];
                            end
                            cache_count++;
                        end
                        len = (req.apdu_len > BYTES_MAX) ? BYTES_MAX : req.apdu_len;
                        cache_group[slot]  = req.group_addr;
                        cache_source[slot] = req.source_addr;
                        cache_len[slot]    = 4'(len);
                        cache_value[slot]  = (len >= 8) ? req.apdu_bytes :
                            req.apdu_bytes & ((64'd1 << (len * 8)) - 64'd1);
                        cache_stamp[slot]  = req.now_seconds;
                        ring[ring_position[7:0]] = req.group_addr;
                        ring_position++;
                        ans.status = gavc_pkg::ST_STORED;
                    end
                end
            end
            gavc_pkg::KIND_LOOKUP:
            begin
                if (!enabled)
                    ans.status = gavc_pkg::ST_DISABLED;
                else
                begin
                    ans.entry_group = req.group_addr;
                    ans.status = gavc_pkg::ST_MISS;
                    if (find_slot(req.group_addr, slot) &&
                        !(req.max_age != 0 &&
                          {1'b0, cache_stamp[slot]} + 33'(req.max_age) <
                          {1'b0, req.now_seconds}))
                    begin
                        ans.status       = gavc_pkg::ST_HIT;
                        ans.entry_source = cache_source[slot];
                        ans.entry_len    = cache_len[slot];
                        ans.entry_bytes  = cache_value[slot];
                    end
                end
            end
            gavc_pkg::KIND_REMOVE:
            begin
                ans.entry_group = req.group_addr;
                ans.status = gavc_pkg::ST_MISS;
                if (find_slot(req.group_addr, slot))
                begin
                    for (int i = slot; i + 1 < cache_count; i++)
                    begin
                        cache_group[i]  = cache_group[i+1];
                        cache_source[i] = cache_source[i+1];
                        cache_len[i]    = cache_len[i+1];
                        cache_value[i]  = cache_value[i+1];
                        cache_stamp[i]  = cache_stamp[i+1];
                    end
                    cache_count--;
                    ans.status = gavc_pkg::ST_HIT;
                end
            end
            gavc_pkg::KIND_CLEAR:
            begin
                cache_count = 0;
                ans.status = gavc_pkg::ST_STORED;
            end
            gavc_pkg::KIND_LOG:
            begin
                pos = ring_position;
                low = pos - 16'(gavc_pkg::LOG_DEPTH);
                at  = req.log_start;
                if (pos < gavc_pkg::LOG_DEPTH)
                begin
                    if (pos < at && at < low)
                        at = low;
                end
                else if (at < low || at > pos)
                    at = low;
                while (at != pos && ring[at[7:0]] == 16'd0)
                    at++;
                if (at != pos)
                begin
                    ans.status      = gavc_pkg::ST_LOG_ENTRY;
                    ans.entry_group = ring[at[7:0]];
                    ans.log_next    = at + 16'd1;
                end
                else
                begin
                    ans.status   = gavc_pkg::ST_LOG_EMPTY;
                    ans.log_next = pos;
                end
                ans.log_end = pos;
            end
            default:
                ans.status = gavc_pkg::ST_IGNORED;
        endcase
        return ans;
    endfunction

    // send one request and wait for its transfer
    task automatic send_request(input request_t req);
        kind        <= req.kind;
        group_addr  <= req.group_addr;
        source_addr <= req.source_addr;
        apdu_len    <= req.apdu_len;
        apdu_bytes  <= req.apdu_bytes;
        now_seconds <= req.now_seconds;
        max_age     <= req.max_age;
        log_start   <= req.log_start;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_answers.push_back(cache_predict(req));
    endtask

    // sender gap between bursts
    task automatic maybe_pause();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain every expected result, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        enabled = value;
        if (!value)
            cache_count = 0;
    endtask

    function automatic request_t make_telegram(input logic [15:0] addr,
                                               input logic [3:0] len,
                                               input logic [7:0] b0,
                                               input logic [7:0] b1);
        request_t req;
        req = '0;
        req.kind        = gavc_pkg::KIND_TELEGRAM;
        req.group_addr  = addr;
        req.source_addr = 16'($urandom);
        req.apdu_len    = len;
        req.apdu_bytes  = {$urandom, $urandom};
        req.apdu_bytes[15:0] = {b1, b0};
        req.now_seconds = clock_seconds;
        return req;
    endfunction

    function automatic request_t make_simple(input logic [2:0] k, input logic [15:0] addr);
        request_t req;
        req = '0;
        req.kind        = k;
        req.group_addr  = addr;
        req.now_seconds = clock_seconds;
        return req;
    endfunction

    // disabled behavior and telegram filtering
    task automatic test_filter();
        request_t req;
        send_request(make_telegram(16'h0101, 4'd2, 8'h00, 8'h80));
        send_request(make_simple(gavc_pkg::KIND_LOOKUP, 16'h0101));
        wait_idle();
        write_enable(1'b1);
        send_request(make_telegram(16'h0101, 4'd1, 8'h00, 8'h80));
        send_request(make_telegram(16'h0101, 4'd0, 8'h00, 8'h80));
        send_request(make_telegram(16'h0101, 4'd4, 8'h03, 8'h80));
        send_request(make_telegram(16'h0101, 4'd4, 8'h00, 8'h00));
        send_request(make_telegram(16'h0101, 4'd4, 8'h00, 8'hC0));
        send_request(make_telegram(16'h0000, 4'd2, 8'h00, 8'h40));
        send_request(make_telegram(16'hFFFF, 4'd15, 8'hFC, 8'hBF));
        send_request(make_telegram(16'h0101, 4'd8, 8'h00, 8'h80));
        req = make_simple(gavc_pkg::KIND_LOOKUP, 16'hFFFF);
        send_request(req);
        req = make_simple(gavc_pkg::KIND_LOOKUP, 16'h0000);
        send_request(req);
    endtask

    // lookup age limit and the no-limit case
    task automatic test_lookup_age();
        request_t req;
        req = make_simple(gavc_pkg::KIND_LOOKUP, 16'h0101);
        req.max_age = 16'd5;
        req.now_seconds = clock_seconds + 5;
        send_request(req);
        req.now_seconds = clock_seconds + 6;
        send_request(req);
        req.max_age = 16'hFFFF;
        req.now_seconds = 32'hFFFF_FFFF;
        send_request(req);
        req.max_age = 16'd0;
        send_request(req);
        send_request(make_simple(gavc_pkg::KIND_LOOKUP, 16'h0202));
    endtask

    // remove, clear, log queries and unknown kinds
    task automatic test_edit_and_log();
        request_t req;
        send_request(make_simple(gavc_pkg::KIND_REMOVE, 16'h0000));
        send_request(make_simple(gavc_pkg::KIND_REMOVE, 16'h0000));
        req = make_simple(gavc_pkg::KIND_LOG, 16'h0);
        send_request(req);
        req.log_start = 16'hFFFF;
        send_request(req);
        req.log_start = 16'd2;
        send_request(req);
        send_request(make_simple(gavc_pkg::KIND_CLEAR, 16'h0));
        send_request(make_simple(gavc_pkg::KIND_LOOKUP, 16'hFFFF));
        send_request(make_simple(3'd5, 16'h1234));
        send_request(make_simple(3'd7, 16'hFFFF));
        wait_idle();
        write_enable(1'b0);
        send_request(make_simple(gavc_pkg::KIND_REMOVE, 16'h0101));
        send_request(make_simple(gavc_pkg::KIND_LOG, 16'h0));
        wait_idle();
    endtask

    function automatic request_t random_request();
        request_t    req;
        int          pick;
        logic [15:0] addr;
        logic [7:0]  b1;
        pick = $urandom_range(0, 99);
        addr = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                            : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 3) == 0)
            clock_seconds += $urandom_range(0, 40);
        if (pick < 50)
        begin
            b1 = {($urandom_range(0, 1) ? 2'b01 : 2'b10), 6'($urandom)};
            req = make_telegram(addr, 4'($urandom_range(2, 8)), {6'($urandom), 2'b00}, b1);
            // occasional noise: broken apci or length
            if ($urandom_range(0, 9) == 0)
            begin
                req.apdu_len = 4'($urandom);
                req.apdu_bytes[15:0] = 16'($urandom);
            end
        end
        else
        begin
            req = make_simple(gavc_pkg::KIND_LOOKUP, addr);
            if (pick < 80)
                req.max_age = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 60));
            else if (pick < 88)
                req.kind = gavc_pkg::KIND_REMOVE;
            else if (pick < 89)
                req.kind = gavc_pkg::KIND_CLEAR;
            else if (pick < 98)
            begin
                req.kind = gavc_pkg::KIND_LOG;
                req.log_start = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                : ring_position - 16'($urandom_range(0, 300));
            end
            else
                req.kind = 3'($urandom_range(5, 7));
        end
        // rare fully random fields
        if ($urandom_range(0, 15) == 0)
        begin
            req.source_addr = 16'($urandom);
            req.now_seconds = $urandom;
            req.max_age     = 16'($urandom);
            req.log_start   = 16'($urandom);
        end
        return req;
    endfunction

    // random phases with the cache switched between settings
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_enable((phase == 3) ? 1'b0 : 1'b1);
            for (int n = 0; n < 170; n++)
            begin
                send_request(random_request());
                maybe_pause();
            end
            wait_idle();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (done)
        begin
            got = {status, entry_source, entry_group, entry_len, entry_bytes,
                   log_next, log_end};
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got != want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < gavc_pkg::LOG_DEPTH; i++)
            ring[i] = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = 16'($urandom);
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_filter();
        test_lookup_age();
        test_edit_and_log();
        test_random();
        if (pending_answers.size() == 0 && mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
